// File: sv/spq_pkg.sv
// Shared types and codes for the stable priority queue.
package spq_pkg;

  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_DEQUEUE = 1'b1;

  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic        operation;
    logic [15:0] item_id;
    logic [7:0]  severity;
  } in_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] removed_id;
    logic [7:0]  removed_severity;
    logic [15:0] head_id;
    logic [7:0]  head_severity;
    logic        is_empty;
    logic [4:0]  entry_count;
  } out_rsp_t;

  // controller to datapath
  typedef struct packed {
    logic       load;
    logic       enq;
    logic       deq;
    logic [1:0] status;
  } spq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
  } spq_sts_t;

endpackage

// File: sv/spq_ctrl.sv
// Request handshake and result hold controller for the stable priority queue.
module spq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              operation_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  spq_pkg::spq_sts_t sts_i,
  output spq_pkg::spq_cmd_t cmd_o
);
  import spq_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_HOLD = 1'b1;

  logic state_q, state_d;
  logic accept;

  assign in_ready_o  = (state_q == S_IDLE) || out_ready_i;
  assign out_valid_o = (state_q == S_HOLD);
  assign accept      = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o.load   = accept;
    cmd_o.enq    = 1'b0;
    cmd_o.deq    = 1'b0;
    cmd_o.status = STATUS_DONE;
    if (operation_i == OP_ENQUEUE) begin
      if (sts_i.full) begin
        cmd_o.status = STATUS_FULL;
      end else begin
        cmd_o.enq = accept;
      end
    end else begin
      if (sts_i.empty) begin
        cmd_o.status = STATUS_EMPTY;
      end else begin
        cmd_o.deq = accept;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_HOLD;
      end
      S_HOLD: begin
        // a new request refills the result register as the old one leaves
        if (!accept && out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: sv/spq_datapath.sv
// Sorted slot chain, occupancy counter and result register of the priority queue.
module spq_datapath #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  spq_pkg::in_req_t  req_i,
  input  spq_pkg::spq_cmd_t cmd_i,
  output spq_pkg::spq_sts_t sts_o,
  output spq_pkg::out_rsp_t rsp_o
);
  import spq_pkg::*;

  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  logic [15:0]         id_q  [QUEUE_DEPTH];
  logic [7:0]          sev_q [QUEUE_DEPTH];
  logic [CntW-1:0]     count_q, count_d;
  logic [QUEUE_DEPTH-1:0] take;
  out_rsp_t            rsp_q, rsp_d;

  assign sts_o.full  = (count_q == CntW'(QUEUE_DEPTH));
  assign sts_o.empty = (count_q == '0);

  // a slot takes part in the insert when it is empty or holds a strictly lower severity
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    assign take[i] = (CntW'(i) >= count_q) || (sev_q[i] < req_i.severity);

    always_ff @(posedge clk_i) begin
      if (cmd_i.enq && take[i]) begin
        if (i > 0 && take[(i > 0) ? i - 1 : 0]) begin
          id_q[i]  <= id_q[(i > 0) ? i - 1 : 0];
          sev_q[i] <= sev_q[(i > 0) ? i - 1 : 0];
        end else begin
          id_q[i]  <= req_i.item_id;
          sev_q[i] <= req_i.severity;
        end
      end else if (cmd_i.deq && i < QUEUE_DEPTH - 1) begin
        id_q[i]  <= id_q[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
        sev_q[i] <= sev_q[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.enq) count_d = count_q + CntW'(1);
    if (cmd_i.deq) count_d = count_q - CntW'(1);
  end

  always_comb begin
    rsp_d                  = '0;
    rsp_d.status           = cmd_i.status;
    rsp_d.is_empty         = (count_d == '0);
    rsp_d.entry_count      = 5'(count_d);
    if (cmd_i.enq) begin
      if (take[0]) begin
        rsp_d.head_id       = req_i.item_id;
        rsp_d.head_severity = req_i.severity;
      end else begin
        rsp_d.head_id       = id_q[0];
        rsp_d.head_severity = sev_q[0];
      end
    end else if (cmd_i.deq) begin
      rsp_d.removed_id       = id_q[0];
      rsp_d.removed_severity = sev_q[0];
      if (count_q > CntW'(1)) begin
        rsp_d.head_id       = id_q[1];
        rsp_d.head_severity = sev_q[1];
      end
    end else if (count_q != '0) begin
      rsp_d.head_id       = id_q[0];
      rsp_d.head_severity = sev_q[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) rsp_q <= rsp_d;
  end

  assign rsp_o = rsp_q;

endmodule

// File: sv/stable_priority_queue.sv
// Top level of the stable priority queue: controller and slot-chain datapath.
// Latency: a result is valid the cycle after its request is accepted.
// Throughput: one request per cycle while out_ready_i is high; every slot compares with the
// new severity in parallel and the chain shifts at once; only the result register stalls.
// Reset: rst_ni clears the occupancy count and the result-valid state; slot contents
// are not cleared and are never shown before they are written.
module stable_priority_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  spq_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output spq_pkg::out_rsp_t out_rsp_o
);
  import spq_pkg::*;

  spq_cmd_t cmd;
  spq_sts_t sts;

  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (in_req_i.operation),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  spq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (in_req_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .rsp_o  (out_rsp_o)
  );

endmodule

// File: sim/spq_checker.sv
// Checker for the stable priority queue: predicts each request's response and compares.
`timescale 1ns / 1ps

module spq_checker #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  spq_pkg::in_req_t  in_req_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  spq_pkg::out_rsp_t out_rsp_i,
  output int unsigned       error_count_o,
  output int unsigned       pending_o
);
  import spq_pkg::*;

  logic [15:0] slot_id  [QUEUE_DEPTH];
  logic [7:0]  slot_sev [QUEUE_DEPTH];
  int unsigned held;
  out_rsp_t    awaited_rsps[$];
  int unsigned errors;

  // Apply one request to the shadow queue and return the response it should give.
  function automatic out_rsp_t apply_request(in_req_t req);
    out_rsp_t rsp;
    int unsigned pos;
    bit found;
    rsp = '0;
    found = 1'b0;
    if (req.operation == OP_ENQUEUE) begin
      if (held >= QUEUE_DEPTH) begin
        rsp.status = STATUS_FULL;
      end else begin
        pos = held;
        // first slot of strictly lower severity keeps equal severities in arrival order
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
          if (!found && i < held && slot_sev[i] < req.severity) begin
            pos = i;
            found = 1'b1;
          end
        end
        for (int i = QUEUE_DEPTH - 1; i > 0; i--) begin
          if (i <= held && i > pos) begin
            slot_id[i]  = slot_id[i-1];
            slot_sev[i] = slot_sev[i-1];
          end
        end
        slot_id[pos]  = req.item_id;
        slot_sev[pos] = req.severity;
        held++;
        rsp.status = STATUS_DONE;
      end
    end else begin
      if (held == 0) begin
        rsp.status = STATUS_EMPTY;
      end else begin
        rsp.status           = STATUS_DONE;
        rsp.removed_id       = slot_id[0];
        rsp.removed_severity = slot_sev[0];
        for (int i = 1; i < QUEUE_DEPTH; i++) begin
          if (i < held) begin
            slot_id[i-1]  = slot_id[i];
            slot_sev[i-1] = slot_sev[i];
          end
        end
        held--;
      end
    end
    if (held != 0) begin
      rsp.head_id       = slot_id[0];
      rsp.head_severity = slot_sev[0];
    end
    rsp.is_empty    = (held == 0);
    rsp.entry_count = held[4:0];
    return rsp;
  endfunction

  task automatic check_field(string name, int unsigned exp_val, int unsigned act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, exp_val,
               act_val);
      errors++;
    end
  endtask

  initial begin
    out_rsp_t exp_rsp;
    errors        = 0;
    held          = 0;
    error_count_o = 0;
    pending_o     = 0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni) begin
        held = 0;
        awaited_rsps.delete();
      end else begin
        // compare first: a response leaving at this edge belongs to an older request
        if (out_valid_i && out_ready_i) begin
          if (awaited_rsps.size() == 0) begin
            $display("%0t: unexpected response 0x%0h, nothing expected", $time, out_rsp_i);
            errors++;
          end else begin
            exp_rsp = awaited_rsps.pop_front();
            check_field("status", exp_rsp.status, out_rsp_i.status);
            check_field("removed_id", exp_rsp.removed_id, out_rsp_i.removed_id);
            check_field("removed_severity", exp_rsp.removed_severity,
                        out_rsp_i.removed_severity);
            check_field("head_id", exp_rsp.head_id, out_rsp_i.head_id);
            check_field("head_severity", exp_rsp.head_severity, out_rsp_i.head_severity);
            check_field("is_empty", exp_rsp.is_empty, out_rsp_i.is_empty);
            check_field("entry_count", exp_rsp.entry_count, out_rsp_i.entry_count);
          end
        end
        if (in_valid_i && in_ready_i) begin
          awaited_rsps.push_back(apply_request(in_req_i));
        end
      end
      error_count_o = errors;
      pending_o     = awaited_rsps.size();
    end
  end

endmodule

// File: sim/tb_top.sv
// Testbench top for the stable priority queue: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
  import spq_pkg::*;

  localparam int QUEUE_DEPTH = 16;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  in_req_t     in_req_i;
  logic        out_valid_o;
  logic        out_ready_i;
  out_rsp_t    out_rsp_o;
  int unsigned error_count;
  int unsigned pending;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  stable_priority_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );

  spq_checker #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_req_i     (in_req_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_rsp_i    (out_rsp_o),
    .error_count_o(error_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ready_i <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Hold the request until accepted, with random idle cycles in front.
  task automatic send_request(logic op, logic [15:0] id, logic [7:0] sev);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i         <= 1'b1;
    in_req_i.operation <= op;
    in_req_i.item_id   <= id;
    in_req_i.severity  <= sev;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    logic        op;
    logic [7:0]  sev;
    bit          filling;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_req_i       = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // empty queue, extremes, ties, fill to the brim, reject on full, then drain a few
    send_request(OP_DEQUEUE, 16'h0000, 8'h00);
    send_request(OP_ENQUEUE, 16'h0000, 8'h00);
    send_request(OP_ENQUEUE, 16'hffff, 8'hff);
    send_request(OP_ENQUEUE, 16'h0001, 8'hff);
    send_request(OP_ENQUEUE, 16'h0002, 8'h00);
    send_request(OP_ENQUEUE, 16'h0003, 8'h80);
    send_request(OP_ENQUEUE, 16'h0004, 8'h80);
    send_request(OP_ENQUEUE, 16'h0005, 8'h7f);
    send_request(OP_ENQUEUE, 16'h0006, 8'h81);
    send_request(OP_ENQUEUE, 16'haaaa, 8'h55);
    send_request(OP_ENQUEUE, 16'h5555, 8'haa);
    send_request(OP_ENQUEUE, 16'h0008, 8'h01);
    send_request(OP_ENQUEUE, 16'h0009, 8'hfe);
    send_request(OP_ENQUEUE, 16'h000a, 8'h80);
    send_request(OP_ENQUEUE, 16'h000b, 8'h00);
    send_request(OP_ENQUEUE, 16'h000c, 8'hff);
    send_request(OP_ENQUEUE, 16'h000d, 8'h40);
    send_request(OP_ENQUEUE, 16'hffff, 8'hff);
    send_request(OP_DEQUEUE, 16'hffff, 8'hff);
    send_request(OP_DEQUEUE, 16'h1234, 8'h5a);
    send_request(OP_DEQUEUE, 16'h0000, 8'h00);
    send_request(OP_DEQUEUE, 16'h0000, 8'h00);

    // per idling phase, alternate fill-heavy and drain-heavy stretches to hit full and empty
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      for (int stretch = 0; stretch < 4; stretch++) begin
        filling = (stretch % 2 == 0);
        repeat (32) begin
          op = ($urandom_range(99) < (filling ? 25 : 75)) ? OP_DEQUEUE : OP_ENQUEUE;
          // narrow severities most of the time so ties are common
          sev = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(3));
          send_request(op, 16'($urandom_range(65535)), sev);
        end
      end
    end
    in_valid_i <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (5) @(negedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
